### rtl/spv_pkg.sv
package spv_pkg;

  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  // packet and payload sizes of the three formats
  localparam logic [COUNT_W-1:0] OLD_PACKET_LEN    = 6'd32;
  localparam logic [COUNT_W-1:0] NEW_PACKET_LEN    = 6'd48;
  localparam logic [COUNT_W-1:0] HEALTH_PACKET_LEN = 6'd28;
  localparam logic [15:0] OLD_PAYLOAD_LEN    = 16'd24;
  localparam logic [15:0] NEW_PAYLOAD_LEN    = 16'd40;
  localparam logic [15:0] HEALTH_PAYLOAD_LEN = 16'd20;

  // header byte offsets
  localparam logic [COUNT_W-1:0] OFS_MAGIC_LO = 6'd0;
  localparam logic [COUNT_W-1:0] OFS_MAGIC_HI = 6'd1;
  localparam logic [COUNT_W-1:0] OFS_VERSION  = 6'd2;
  localparam logic [COUNT_W-1:0] OFS_KIND     = 6'd3;
  localparam logic [COUNT_W-1:0] OFS_PLEN_LO  = 6'd4;
  localparam logic [COUNT_W-1:0] OFS_PLEN_HI  = 6'd5;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_LENGTH   = 3'd1,
    VERDICT_MAGIC    = 3'd2,
    VERDICT_VERSION  = 3'd3,
    VERDICT_KIND     = 3'd4,
    VERDICT_PAYLOAD  = 3'd5,
    VERDICT_CHECKSUM = 3'd6
  } verdict_t;

  typedef enum logic [2:0] {
    REG_FRAME_MAGIC = 3'd0,
    REG_OLD_VERSION = 3'd1,
    REG_NEW_VERSION = 3'd2,
    REG_SAMPLE_KIND = 3'd3,
    REG_HEALTH_KIND = 3'd4
  } reg_index_t;

endpackage

### rtl/sensor_packet_validator.sv
// the verdict is registered and reaches the output in the cycle after the last byte of a packet is accepted
// throughput: one byte per cycle; header capture, checksum add and verdict all fit in one pass
// a last byte waits only while a previous verdict sits stalled in the output register
// reset: synchronous, active high; clears the packet state and output valid,
// and returns the configuration registers to their default values
module sensor_packet_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  verdict,
  output logic [7:0]  seen_version,
  output logic [7:0]  seen_kind,
  output logic [15:0] seen_payload_len,
  output logic [5:0]  total_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] frame_magic;
  logic [7:0]  old_version;
  logic [7:0]  new_version;
  logic [7:0]  sample_kind;
  logic [7:0]  health_kind;

  logic [spv_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] held_magic, held_magic_next;
  logic [7:0]  held_version, held_version_next;
  logic [7:0]  held_kind, held_kind_next;
  logic [15:0] held_payload_len, held_payload_len_next;
  logic [15:0] trailer_delay, trailer_delay_next;

  spv_pkg::verdict_t verdict_reg, verdict_next;
  logic in_acc;

  assign cfg_ready = 1'b1;
  // only a last byte needs room in the output register
  assign in_stall  = out_valid && out_stall && end_of_packet;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic <= 16'd0;
      old_version <= 8'd1;
      new_version <= 8'd2;
      sample_kind <= 8'd1;
      health_kind <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spv_pkg::REG_FRAME_MAGIC: frame_magic <= cfg_data;
        spv_pkg::REG_OLD_VERSION: old_version <= cfg_data[7:0];
        spv_pkg::REG_NEW_VERSION: new_version <= cfg_data[7:0];
        spv_pkg::REG_SAMPLE_KIND: sample_kind <= cfg_data[7:0];
        spv_pkg::REG_HEALTH_KIND: health_kind <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    held_magic_next       = held_magic;
    held_version_next     = held_version;
    held_kind_next        = held_kind;
    held_payload_len_next = held_payload_len;
    case (byte_count)
      spv_pkg::OFS_MAGIC_LO: held_magic_next[7:0]        = data_byte;
      spv_pkg::OFS_MAGIC_HI: held_magic_next[15:8]       = data_byte;
      spv_pkg::OFS_VERSION:  held_version_next           = data_byte;
      spv_pkg::OFS_KIND:     held_kind_next              = data_byte;
      spv_pkg::OFS_PLEN_LO:  held_payload_len_next[7:0]  = data_byte;
      spv_pkg::OFS_PLEN_HI:  held_payload_len_next[15:8] = data_byte;
      default: ;
    endcase
    // a byte joins the sum once two newer bytes have pushed it out of the trailer window
    if (byte_count >= spv_pkg::OFS_VERSION) begin
      running_sum_next = running_sum + {8'd0, trailer_delay[7:0]};
    end else begin
      running_sum_next = running_sum;
    end
    trailer_delay_next = {data_byte, trailer_delay[15:8]};
    if (byte_count != spv_pkg::COUNT_MAX) begin
      byte_count_next = byte_count + 6'd1;
    end else begin
      byte_count_next = byte_count;
    end
  end

  logic len_ok, is_old, is_new, is_sample, is_health;
  logic health_ok, old_ok, new_ok;

  always_comb begin
    len_ok    = (byte_count_next == spv_pkg::OLD_PACKET_LEN) ||
                (byte_count_next == spv_pkg::NEW_PACKET_LEN) ||
                (byte_count_next == spv_pkg::HEALTH_PACKET_LEN);
    is_old    = held_version_next == old_version;
    is_new    = held_version_next == new_version;
    is_sample = held_kind_next == sample_kind;
    is_health = held_kind_next == health_kind;
    health_ok = is_new && (byte_count_next == spv_pkg::HEALTH_PACKET_LEN) &&
                (held_payload_len_next == spv_pkg::HEALTH_PAYLOAD_LEN);
    old_ok    = !is_old || ((byte_count_next == spv_pkg::OLD_PACKET_LEN) &&
                (held_payload_len_next == spv_pkg::OLD_PAYLOAD_LEN));
    new_ok    = !is_new || ((byte_count_next == spv_pkg::NEW_PACKET_LEN) &&
                (held_payload_len_next == spv_pkg::NEW_PAYLOAD_LEN));
    if (!len_ok) begin
      verdict_next = spv_pkg::VERDICT_LENGTH;
    end else if (held_magic_next != frame_magic) begin
      verdict_next = spv_pkg::VERDICT_MAGIC;
    end else if (!is_old && !is_new) begin
      verdict_next = spv_pkg::VERDICT_VERSION;
    end else if (!is_sample && !is_health) begin
      verdict_next = spv_pkg::VERDICT_KIND;
    end else if (is_health ? !health_ok : !(old_ok && new_ok)) begin
      verdict_next = spv_pkg::VERDICT_PAYLOAD;
    end else if (trailer_delay_next != running_sum_next) begin
      verdict_next = spv_pkg::VERDICT_CHECKSUM;
    end else begin
      verdict_next = spv_pkg::VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      running_sum      <= 16'd0;
      held_magic       <= 16'd0;
      held_version     <= 8'd0;
      held_kind        <= 8'd0;
      held_payload_len <= 16'd0;
      trailer_delay    <= 16'd0;
    end else if (in_acc) begin
      if (end_of_packet) begin
        byte_count       <= '0;
        running_sum      <= 16'd0;
        held_magic       <= 16'd0;
        held_version     <= 8'd0;
        held_kind        <= 8'd0;
        held_payload_len <= 16'd0;
        trailer_delay    <= 16'd0;
      end else begin
        byte_count       <= byte_count_next;
        running_sum      <= running_sum_next;
        held_magic       <= held_magic_next;
        held_version     <= held_version_next;
        held_kind        <= held_kind_next;
        held_payload_len <= held_payload_len_next;
        trailer_delay    <= trailer_delay_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && end_of_packet) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && end_of_packet) begin
      verdict_reg      <= verdict_next;
      seen_version     <= held_version_next;
      seen_kind        <= held_kind_next;
      seen_payload_len <= held_payload_len_next;
      total_bytes      <= byte_count_next;
    end
  end

  assign verdict = verdict_reg;

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && end_of_packet |=> byte_count == '0 && running_sum == 16'd0)
    else $error("packet state not cleared after last item");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !end_of_packet && byte_count != spv_pkg::COUNT_MAX
    |=> byte_count == $past(byte_count) + 6'd1)
    else $error("byte count did not advance");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc && end_of_packet |=> out_valid)
    else $error("no result after last item");

  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == spv_pkg::VERDICT_OK
    |-> total_bytes == spv_pkg::OLD_PACKET_LEN || total_bytes == spv_pkg::NEW_PACKET_LEN ||
        total_bytes == spv_pkg::HEALTH_PACKET_LEN)
    else $error("ok verdict with illegal length");

endmodule

### verif/sensor_packet_validator_tb.sv
`timescale 1ns / 1ps

module sensor_packet_validator_tb;
  import spv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 180;
  localparam int PHASE_PACKETS = 5;
  localparam int LONG_HOLD = 300;
  // no register sits at this index, a write to it must change nothing
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef enum {FMT_OLD, FMT_NEW, FMT_HEALTH, FMT_NOISE} shape_t;
  typedef enum {FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_KIND, FLAW_PLEN, FLAW_SUM} flaw_t;

  typedef struct {
    verdict_t    code;
    logic [7:0]  version;
    logic [7:0]  kind;
    logic [15:0] plen;
    logic [5:0]  total;
  } verdict_rec_t;

  typedef struct {
    shape_t       shape;
    int           len;
    flaw_t        flaw;
    int           fill;
    bit           typed;
    verdict_rec_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  verdict;
  logic [7:0]  seen_version;
  logic [7:0]  seen_kind;
  logic [15:0] seen_payload_len;
  logic [5:0]  total_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'h0000;

  logic rx_stall = 1'b0;
  logic hold_off = 1'b0;
  bit   hold_go = 1'b0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;

  assign out_stall = rx_stall | hold_off;

  sensor_packet_validator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .end_of_packet(end_of_packet),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict),
    .seen_version(seen_version),
    .seen_kind(seen_kind),
    .seen_payload_len(seen_payload_len),
    .total_bytes(total_bytes),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register shadow
  logic [15:0] cfg_magic = 16'h0000;
  logic [7:0]  cfg_old_ver = 8'd1;
  logic [7:0]  cfg_new_ver = 8'd2;
  logic [7:0]  cfg_sample = 8'd1;
  logic [7:0]  cfg_health = 8'd2;

  // packet-in-progress state of the predictor
  logic [5:0]  pk_count = '0;
  logic [15:0] pk_sum = '0;
  logic [15:0] pk_magic = '0;
  logic [7:0]  pk_version = '0;
  logic [7:0]  pk_kind = '0;
  logic [15:0] pk_plen = '0;
  logic [15:0] pk_tail = '0;

  verdict_rec_t pending_verdicts[$];
  logic [7:0]   byte_q[$];
  bit           want_typed = 1'b0;
  verdict_rec_t typed_want;
  int           bytes_sent = 0;
  int           packets_judged = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  plan_row_t plan [16] = '{
    '{FMT_NOISE, 1, FLAW_NONE, 'hFF, 1'b1, '{VERDICT_LENGTH, 8'h00, 8'h00, 16'h0000, 6'd1}},
    '{FMT_NOISE, 1, FLAW_NONE, 'h00, 1'b1, '{VERDICT_LENGTH, 8'h00, 8'h00, 16'h0000, 6'd1}},
    '{FMT_NOISE, 2, FLAW_NONE, 'hFF, 1'b1, '{VERDICT_LENGTH, 8'h00, 8'h00, 16'h0000, 6'd2}},
    '{FMT_NOISE, 6, FLAW_NONE, -1, 1'b0, '{VERDICT_OK, 8'h00, 8'h00, 16'h0000, 6'd0}},
    '{FMT_HEALTH, 0, FLAW_NONE, -1, 1'b1, '{VERDICT_OK, 8'd2, 8'd2, 16'd20, 6'd28}},
    '{FMT_OLD, 0, FLAW_NONE, -1, 1'b1, '{VERDICT_OK, 8'd1, 8'd1, 16'd24, 6'd32}},
    '{FMT_NEW, 0, FLAW_NONE, -1, 1'b1, '{VERDICT_OK, 8'd2, 8'd1, 16'd40, 6'd48}},
    '{FMT_HEALTH, 0, FLAW_MAGIC, -1, 1'b1, '{VERDICT_MAGIC, 8'd2, 8'd2, 16'd20, 6'd28}},
    '{FMT_HEALTH, 0, FLAW_VERSION, -1, 1'b0, '{VERDICT_OK, 8'h00, 8'h00, 16'h0000, 6'd0}},
    '{FMT_OLD, 0, FLAW_KIND, -1, 1'b0, '{VERDICT_OK, 8'h00, 8'h00, 16'h0000, 6'd0}},
    '{FMT_NEW, 0, FLAW_PLEN, -1, 1'b0, '{VERDICT_OK, 8'h00, 8'h00, 16'h0000, 6'd0}},
    '{FMT_HEALTH, 0, FLAW_SUM, -1, 1'b1, '{VERDICT_CHECKSUM, 8'd2, 8'd2, 16'd20, 6'd28}},
    '{FMT_OLD, 48, FLAW_NONE, -1, 1'b1, '{VERDICT_PAYLOAD, 8'd1, 8'd1, 16'd24, 6'd48}},
    '{FMT_HEALTH, 31, FLAW_NONE, -1, 1'b1, '{VERDICT_LENGTH, 8'd2, 8'd2, 16'd20, 6'd31}},
    '{FMT_NOISE, 63, FLAW_NONE, 'h5A, 1'b1, '{VERDICT_LENGTH, 8'h5A, 8'h5A, 16'h5A5A, 6'd63}},
    '{FMT_NOISE, 70, FLAW_NONE, 'hA5, 1'b1, '{VERDICT_LENGTH, 8'hA5, 8'hA5, 16'hA5A5, 6'd63}}
  };

  function automatic verdict_t grade_packet();
    if (pk_count != OLD_PACKET_LEN && pk_count != NEW_PACKET_LEN &&
        pk_count != HEALTH_PACKET_LEN)
      return VERDICT_LENGTH;
    if (pk_magic != cfg_magic)
      return VERDICT_MAGIC;
    if (pk_version != cfg_old_ver && pk_version != cfg_new_ver)
      return VERDICT_VERSION;
    if (pk_kind != cfg_sample && pk_kind != cfg_health)
      return VERDICT_KIND;
    // health rules win when both kind codes are the same
    if (pk_kind == cfg_health) begin
      if (pk_version != cfg_new_ver || pk_count != HEALTH_PACKET_LEN ||
          pk_plen != HEALTH_PAYLOAD_LEN)
        return VERDICT_PAYLOAD;
    end else begin
      if (pk_version == cfg_old_ver &&
          (pk_count != OLD_PACKET_LEN || pk_plen != OLD_PAYLOAD_LEN))
        return VERDICT_PAYLOAD;
      if (pk_version == cfg_new_ver &&
          (pk_count != NEW_PACKET_LEN || pk_plen != NEW_PAYLOAD_LEN))
        return VERDICT_PAYLOAD;
    end
    if (pk_tail != pk_sum)
      return VERDICT_CHECKSUM;
    return VERDICT_OK;
  endfunction

  function automatic bit absorb_byte(input logic [7:0] b, input logic last,
                                     output verdict_rec_t rec);
    case (pk_count)
      OFS_MAGIC_LO: pk_magic[7:0] = b;
      OFS_MAGIC_HI: pk_magic[15:8] = b;
      OFS_VERSION:  pk_version = b;
      OFS_KIND:     pk_kind = b;
      OFS_PLEN_LO:  pk_plen[7:0] = b;
      OFS_PLEN_HI:  pk_plen[15:8] = b;
      default: ;
    endcase
    // a byte joins the sum once two newer bytes have pushed it out of the trailer window
    if (pk_count >= OFS_VERSION)
      pk_sum = pk_sum + 16'(pk_tail[7:0]);
    pk_tail = {b, pk_tail[15:8]};
    if (pk_count != COUNT_MAX)
      pk_count = pk_count + 6'd1;
    if (!last)
      return 1'b0;
    rec.code = grade_packet();
    rec.version = pk_version;
    rec.kind = pk_kind;
    rec.plen = pk_plen;
    rec.total = pk_count;
    pk_count = '0;
    pk_sum = '0;
    pk_magic = '0;
    pk_version = '0;
    pk_kind = '0;
    pk_plen = '0;
    pk_tail = '0;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0d] mismatch: %s", cycle_count, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sensor_packet_validator_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    verdict_rec_t exp_rec;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("verdict %0d with nothing expected", verdict));
      end else begin
        exp_rec = pending_verdicts.pop_front();
        packets_judged++;
        if (verdict !== exp_rec.code)
          flag_mismatch($sformatf("verdict got %0d exp %0d", verdict, exp_rec.code));
        if (seen_version !== exp_rec.version)
          flag_mismatch($sformatf("seen_version got %0h exp %0h", seen_version,
                                  exp_rec.version));
        if (seen_kind !== exp_rec.kind)
          flag_mismatch($sformatf("seen_kind got %0h exp %0h", seen_kind, exp_rec.kind));
        if (seen_payload_len !== exp_rec.plen)
          flag_mismatch($sformatf("seen_payload_len got %0h exp %0h", seen_payload_len,
                                  exp_rec.plen));
        if (total_bytes !== exp_rec.total)
          flag_mismatch($sformatf("total_bytes got %0d exp %0d", total_bytes,
                                  exp_rec.total));
      end
    end
  end

  // result side: a fresh stall draw per item
  initial begin : drain_side
    int unsigned wait_cycles;
    forever begin
      wait_cycles = rx_quiet ? 0 : $urandom_range(0, 14);
      if (wait_cycles != 0) begin
        @(negedge clk);
        rx_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
        rx_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
    end
  end

  // one long hold-off so the output register stays full and the input backs up
  initial begin : long_hold
    wait (hold_go);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    hold_off = 1'b0;
  end

  task automatic offer_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    verdict_rec_t rec;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    end_of_packet = last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (absorb_byte(b, last, rec)) begin
      if (want_typed) pending_verdicts.push_back(typed_want);
      else pending_verdicts.push_back(rec);
      want_typed = 1'b0;
    end
  endtask

  task automatic send_packet();
    for (int i = 0; i < byte_q.size(); i++)
      offer_byte(byte_q[i], i == byte_q.size() - 1);
  endtask

  task automatic compose_packet(input shape_t shape, input int len, input flaw_t flaw,
                                input int fill);
    logic [15:0] magic;
    logic [15:0] plen;
    logic [15:0] sum;
    logic [7:0]  ver;
    logic [7:0]  kind;
    logic [7:0]  hdr [6];
    int n;
    magic = cfg_magic;
    ver = 8'h00;
    kind = 8'h00;
    plen = 16'h0000;
    n = len;
    case (shape)
      FMT_OLD: begin
        n = OLD_PACKET_LEN; ver = cfg_old_ver; kind = cfg_sample; plen = OLD_PAYLOAD_LEN;
      end
      FMT_NEW: begin
        n = NEW_PACKET_LEN; ver = cfg_new_ver; kind = cfg_sample; plen = NEW_PAYLOAD_LEN;
      end
      FMT_HEALTH: begin
        n = HEALTH_PACKET_LEN; ver = cfg_new_ver; kind = cfg_health;
        plen = HEALTH_PAYLOAD_LEN;
      end
      default: ;
    endcase
    if (len != 0) n = len;
    case (flaw)
      FLAW_MAGIC: magic = magic ^ 16'($urandom_range(1, 65535));
      FLAW_VERSION: do ver = 8'($urandom); while (ver == cfg_old_ver || ver == cfg_new_ver);
      FLAW_KIND: do kind = 8'($urandom); while (kind == cfg_sample || kind == cfg_health);
      FLAW_PLEN: plen = plen ^ 16'($urandom_range(1, 65535));
      default: ;
    endcase
    byte_q.delete();
    for (int i = 0; i < n; i++)
      byte_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    if (shape != FMT_NOISE) begin
      hdr = '{magic[7:0], magic[15:8], ver, kind, plen[7:0], plen[15:8]};
      for (int i = 0; i < 6 && i < n; i++)
        byte_q[i] = hdr[i];
      if (n >= 8) begin
        sum = '0;
        for (int i = 0; i < n - 2; i++)
          sum = sum + 16'(byte_q[i]);
        if (flaw == FLAW_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
        byte_q[n-2] = sum[7:0];
        byte_q[n-1] = sum[15:8];
      end
    end
  endtask

  task automatic send_random_packet();
    int r;
    shape_t shape;
    flaw_t flaw;
    int len;
    r = $urandom_range(0, 99);
    shape = shape_t'($urandom_range(0, 2));
    flaw = FLAW_NONE;
    len = 0;
    if (r < 55) begin
      // well-formed, random payload
    end else if (r < 80) begin
      flaw = flaw_t'($urandom_range(1, 5));
    end else if (r < 88) begin
      case ($urandom_range(0, 3))
        0: len = HEALTH_PACKET_LEN;
        1: len = OLD_PACKET_LEN;
        2: len = NEW_PACKET_LEN;
        default: len = $urandom_range(1, 70);
      endcase
    end else if (r < 97) begin
      shape = FMT_NOISE;
      len = $urandom_range(1, 12);
    end else begin
      shape = FMT_NOISE;
      len = $urandom_range(49, 100);
    end
    compose_packet(shape, len, flaw, -1);
    send_packet();
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_MAGIC: cfg_magic = val;
      REG_OLD_VERSION: cfg_old_ver = val[7:0];
      REG_NEW_VERSION: cfg_new_ver = val[7:0];
      REG_SAMPLE_KIND: cfg_sample = val[7:0];
      REG_HEALTH_KIND: cfg_health = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // upper byte of the 8-bit registers carries junk that must be dropped
  task automatic load_config(input logic [15:0] magic, input logic [7:0] old_v,
                             input logic [7:0] new_v, input logic [7:0] samp,
                             input logic [7:0] hlth);
    write_reg(REG_FRAME_MAGIC, magic);
    write_reg(REG_OLD_VERSION, {8'($urandom), old_v});
    write_reg(REG_NEW_VERSION, {8'($urandom), new_v});
    write_reg(REG_SAMPLE_KIND, {8'($urandom), samp});
    write_reg(REG_HEALTH_KIND, {8'($urandom), hlth});
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    end_of_packet = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase_start;
    int phase_packets;
    logic [7:0] same;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      compose_packet(plan[i].shape, plan[i].len, plan[i].flaw, plan[i].fill);
      want_typed = plan[i].typed;
      typed_want = plan[i].want;
      send_packet();
    end

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: load_config(16'hFFFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        1: begin
          same = 8'($urandom);
          load_config(16'($urandom), same, same, 8'($urandom), 8'($urandom));
        end
        2: begin
          same = 8'($urandom);
          load_config(16'h0000, 8'hFF, 8'h00, same, same);
          write_reg(REG_UNUSED, 16'($urandom));
        end
        default: load_config(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
      endcase
      if (phase == 1) begin
        tx_quiet = 1'b1;
        hold_go = 1'b1;
        repeat (12) begin
          compose_packet(FMT_NOISE, $urandom_range(1, 4), FLAW_NONE, -1);
          send_packet();
        end
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      phase_start = bytes_sent;
      phase_packets = 0;
      while (bytes_sent - phase_start < PHASE_BYTES || phase_packets < PHASE_PACKETS) begin
        send_random_packet();
        phase_packets++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("sensor_packet_validator_tb OK");
    else
      $display("sensor_packet_validator_tb NOT OK");
    $finish;
  end

endmodule
